// ===== sv/ikp_pkg.sv =====
package ikp_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ATAN_LEN          = 24;
	localparam int AW                = 48;
	localparam int DW                = 50;
	localparam int ZW                = 26;
	localparam int NORM_STEPS        = 7;
	localparam int NORM_EXP          = 40;
	localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(5898240);

	typedef enum logic [2:0] {
		REG_RADIAL_OFFSET  = 3'd0,
		REG_BASE_HEIGHT    = 3'd1,
		REG_UPPER_LINK     = 3'd2,
		REG_FOREARM_LENGTH = 3'd3,
		REG_FOREARM_ANGLE  = 3'd4
	} reg_idx_t;

	localparam logic [13:0] RADIAL_OFFSET_RST  = 14'd1760;
	localparam logic [13:0] BASE_HEIGHT_RST    = 14'd2656;
	localparam logic [13:0] UPPER_LINK_RST     = 14'd3200;
	localparam logic [13:0] FOREARM_LENGTH_RST = 14'd3200;
	localparam logic [15:0] FOREARM_ANGLE_RST  = 16'd18877;

	// atan(2^-i) in 1/65536 degree
	function automatic logic signed [ZW-1:0] atan_val(input int i);
		logic signed [ZW-1:0] v;
		case (i)
			0: v = ZW'(2949120);
			1: v = ZW'(1740967);
			2: v = ZW'(919879);
			3: v = ZW'(466945);
			4: v = ZW'(234379);
			5: v = ZW'(117304);
			6: v = ZW'(58666);
			7: v = ZW'(29335);
			8: v = ZW'(14668);
			9: v = ZW'(7334);
			10: v = ZW'(3667);
			11: v = ZW'(1833);
			12: v = ZW'(917);
			13: v = ZW'(458);
			14: v = ZW'(229);
			15: v = ZW'(115);
			16: v = ZW'(57);
			17: v = ZW'(29);
			18: v = ZW'(14);
			19: v = ZW'(7);
			20: v = ZW'(4);
			21: v = ZW'(2);
			22: v = ZW'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic int norm_shift(input int k);
		int s;
		case (k)
			0: s = 32;
			1: s = 16;
			2: s = 8;
			3: s = 4;
			4: s = 2;
			default: s = 1;
		endcase
		return s;
	endfunction

	// last step doubles once more when still below the limit
	function automatic logic signed [DW-1:0] norm_limit(input int k);
		int e;
		e = (k == NORM_STEPS - 1) ? NORM_EXP : NORM_EXP - norm_shift(k);
		return {{(DW-1){1'b0}}, 1'b1} << e;
	endfunction

endpackage

// ===== sv/ikp_point_if.sv =====
interface ikp_point_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] target_x;
	logic signed [15:0] target_y;
	logic signed [15:0] target_z;

	modport source(output valid, output target_x, output target_y, output target_z,
		input ready);
	modport sink(input valid, input target_x, input target_y, input target_z,
		output ready);
endinterface

// ===== sv/ikp_joint_if.sv =====
interface ikp_joint_if;
	logic               valid;
	logic               ready;
	logic signed [16:0] base_yaw;
	logic signed [17:0] shoulder_angle;
	logic signed [16:0] elbow_angle;
	logic               reachable;

	modport source(output valid, output base_yaw, output shoulder_angle,
		output elbow_angle, output reachable, input ready);
	modport sink(input valid, input base_yaw, input shoulder_angle,
		input elbow_angle, input reachable, output ready);
endinterface

// ===== sv/ikp_isqrt.sv =====
module ikp_isqrt #(
	parameter int WIDTH  = 32,
	parameter int SIDE_W = 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_vld,
	input  logic [WIDTH-1:0]     in_rad,
	input  logic [SIDE_W-1:0]    in_side,
	output logic                 out_vld,
	output logic [WIDTH/2-1:0]   out_root,
	output logic [SIDE_W-1:0]    out_side
);
	localparam int NS = WIDTH / 2;

	logic              vld_s  [0:NS];
	logic [WIDTH-1:0]  rem_s  [0:NS];
	logic [WIDTH-1:0]  res_s  [0:NS];
	logic [SIDE_W-1:0] side_s [0:NS];

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = in_rad;
	assign res_s[0]  = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < NS; k++) begin : g_step
		localparam logic [WIDTH-1:0] BIT = {{(WIDTH-1){1'b0}}, 1'b1} << (WIDTH - 2 - 2 * k);
		logic [WIDTH:0] trial;
		logic           take;

		assign trial = {1'b0, res_s[k]} + {1'b0, BIT};
		assign take  = ({1'b0, rem_s[k]} >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= take ? rem_s[k] - trial[WIDTH-1:0] : rem_s[k];
				res_s[k+1]  <= take ? (res_s[k] >> 1) + BIT : res_s[k] >> 1;
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign out_vld  = vld_s[NS];
	assign out_root = res_s[NS][NS-1:0];
	assign out_side = side_s[NS];

`ifndef SYNTHESIS
	a_root_fits: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[NS] |-> (res_s[NS][WIDTH-1:NS] == '0))
		else $error("square root overflows its width");
`endif

endmodule

// ===== sv/ikp_cordic.sv =====
module ikp_cordic #(
	parameter int STAGES = ikp_pkg::CORDIC_STAGES_DEF,
	parameter int SIDE_W = 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_vld,
	input  logic signed [ikp_pkg::AW-1:0]    in_y,
	input  logic signed [ikp_pkg::AW-1:0]    in_x,
	input  logic [SIDE_W-1:0]                in_side,
	output logic                             out_vld,
	output logic signed [ikp_pkg::ZW-1:0]    out_ang,
	output logic [SIDE_W-1:0]                out_side
);
	localparam int DW = ikp_pkg::DW;
	localparam int ZW = ikp_pkg::ZW;
	localparam int AW = ikp_pkg::AW;
	localparam int F  = ikp_pkg::NORM_STEPS + 1;
	localparam int NT = F + STAGES;

	logic                 vld_s  [0:NT];
	logic                 zf_s   [0:NT];
	logic signed [DW-1:0] x_s    [0:NT];
	logic signed [DW-1:0] y_s    [0:NT];
	logic signed [ZW-1:0] z_s    [0:NT];
	logic [SIDE_W-1:0]    side_s [0:NT];

	assign vld_s[0]  = in_vld;
	assign zf_s[0]   = (in_x == '0) && (in_y == '0);
	assign x_s[0]    = {{(DW-AW){in_x[AW-1]}}, in_x};
	assign y_s[0]    = {{(DW-AW){in_y[AW-1]}}, in_y};
	assign z_s[0]    = '0;
	assign side_s[0] = in_side;

	for (genvar j = 0; j < NT; j++) begin : g_vld
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (en) begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				zf_s[j+1]   <= zf_s[j];
				side_s[j+1] <= side_s[j];
			end
		end
	end

	// scale up until one magnitude reaches the limit
	for (genvar k = 0; k < ikp_pkg::NORM_STEPS; k++) begin : g_norm
		localparam int                   SH  = ikp_pkg::norm_shift(k);
		localparam logic signed [DW-1:0] LIM = ikp_pkg::norm_limit(k);
		logic small_mag;

		assign small_mag = (x_s[k] < LIM) && (x_s[k] > -LIM)
			&& (y_s[k] < LIM) && (y_s[k] > -LIM);

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[k+1] <= small_mag ? x_s[k] <<< SH : x_s[k];
				y_s[k+1] <= small_mag ? y_s[k] <<< SH : y_s[k];
				z_s[k+1] <= z_s[k];
			end
		end
	end

	// fold the left half plane by a quarter turn
	always_ff @(posedge clk) begin
		if (en) begin
			if (x_s[F-1][DW-1]) begin
				if (!y_s[F-1][DW-1]) begin
					x_s[F] <= y_s[F-1];
					y_s[F] <= -x_s[F-1];
					z_s[F] <= ikp_pkg::QUARTER_TURN;
				end else begin
					x_s[F] <= -y_s[F-1];
					y_s[F] <= x_s[F-1];
					z_s[F] <= -ikp_pkg::QUARTER_TURN;
				end
			end else begin
				x_s[F] <= x_s[F-1];
				y_s[F] <= y_s[F-1];
				z_s[F] <= z_s[F-1];
			end
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_iter
		localparam logic signed [ZW-1:0] ANG = ikp_pkg::atan_val(i);
		logic signed [DW-1:0] dx;
		logic signed [DW-1:0] dy;
		logic                 up;

		assign dx = y_s[F+i] >>> i;
		assign dy = x_s[F+i] >>> i;
		assign up = (y_s[F+i] > 0);

		always_ff @(posedge clk) begin
			if (en) begin
				if (up) begin
					x_s[F+i+1] <= x_s[F+i] + dx;
					y_s[F+i+1] <= y_s[F+i] - dy;
					z_s[F+i+1] <= z_s[F+i] + ANG;
				end else begin
					x_s[F+i+1] <= x_s[F+i] - dx;
					y_s[F+i+1] <= y_s[F+i] + dy;
					z_s[F+i+1] <= z_s[F+i] - ANG;
				end
			end
		end
	end

	assign out_vld  = vld_s[NT];
	assign out_ang  = zf_s[NT] ? '0 : z_s[NT];
	assign out_side = side_s[NT];

`ifndef SYNTHESIS
	a_fold_right: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[F] |-> !x_s[F][DW-1])
		else $error("vector left in the left half plane after fold");
`endif

endmodule

// ===== sv/arm_position_inverse_kinematics_unit.sv =====
// Inverse kinematics for a yawing base carrying a two-link planar arm. Each target
// point word on point yields one joint word on joint: base yaw, shoulder and elbow
// angles in 1/256 degree, or reachable low with all angles zero. A point is taken in
// every cycle while joint is not stalled. The pipeline holds two bit-per-stage square
// roots (16 and 29 stages), seven scaling stages, one quadrant fold and the CORDIC
// stages, plus the arithmetic registers. A stall on joint holds the whole pipeline.
// The user writes geometry registers through wr_en, wr_index and wr_data only while
// no point is in flight; the block itself does not enforce this. Derived products are
// registered from them, densq and l2den in turn from den.
module arm_position_inverse_kinematics_unit #(
	parameter int CORDIC_STAGES = ikp_pkg::CORDIC_STAGES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ikp_point_if.sink   point,
	ikp_joint_if.source joint,
	input  logic        wr_en,
	input  logic [2:0]  wr_index,
	input  logic [15:0] wr_data
);
	localparam int AW = ikp_pkg::AW;
	localparam int ZW = ikp_pkg::ZW;
	localparam int RW = ZW + 2;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [16:0] wz;
	} side_a_t;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [16:0] wz;
		logic        [15:0] wr;
		logic signed [29:0] num;
		logic               reach;
	} side_b_t;

	logic en;

	logic [13:0] radial_offset_q;
	logic [13:0] base_height_q;
	logic [13:0] upper_link_q;
	logic [13:0] forearm_length_q;
	logic [15:0] forearm_angle_q;

	logic [28:0] csum_q;
	logic [28:0] den_q;
	logic [57:0] densq_q;
	logic [42:0] l2den_q;

	assign en          = !joint.valid || joint.ready;
	assign point.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radial_offset_q  <= ikp_pkg::RADIAL_OFFSET_RST;
			base_height_q    <= ikp_pkg::BASE_HEIGHT_RST;
			upper_link_q     <= ikp_pkg::UPPER_LINK_RST;
			forearm_length_q <= ikp_pkg::FOREARM_LENGTH_RST;
			forearm_angle_q  <= ikp_pkg::FOREARM_ANGLE_RST;
		end else if (wr_en) begin
			case (wr_index)
				ikp_pkg::REG_RADIAL_OFFSET:  radial_offset_q  <= wr_data[13:0];
				ikp_pkg::REG_BASE_HEIGHT:    base_height_q    <= wr_data[13:0];
				ikp_pkg::REG_UPPER_LINK:     upper_link_q     <= wr_data[13:0];
				ikp_pkg::REG_FOREARM_LENGTH: forearm_length_q <= wr_data[13:0];
				ikp_pkg::REG_FOREARM_ANGLE:  forearm_angle_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// link-derived constants
	always_ff @(posedge clk) begin
		csum_q  <= {1'b0, {14'd0, upper_link_q} * {14'd0, upper_link_q}}
			+ {1'b0, {14'd0, forearm_length_q} * {14'd0, forearm_length_q}};
		den_q   <= {{14'd0, upper_link_q} * {14'd0, forearm_length_q}, 1'b0};
		densq_q <= {29'd0, den_q} * {29'd0, den_q};
		l2den_q <= {29'd0, upper_link_q} * {14'd0, den_q};
	end

	// s1: input register
	logic               vld_s1;
	logic signed [15:0] x_s1, y_s1, z_s1;

	// s2: squares, wrist height
	logic               vld_s2;
	logic signed [31:0] xsq_s2, ysq_s2;
	logic signed [15:0] x_s2, y_s2;
	logic signed [16:0] wz_s2;

	// s3: radius squared
	logic               vld_s3;
	logic [31:0]        rsq_s3;
	side_a_t            sa_s3;

	logic               rad_vld;
	logic [15:0]        radial;
	side_a_t            sa_rad;

	// s4: wrist radius
	logic               vld_s4;
	logic [15:0]        wr_s4;
	side_a_t            sa_s4;
	logic signed [16:0] wr_diff;

	// s5: wrist squares
	logic               vld_s5;
	logic [31:0]        wrsq_s5;
	logic signed [33:0] wzsq_s5;
	logic [15:0]        wr_s5;
	side_a_t            sa_s5;

	// s6: cosine numerator
	logic               vld_s6;
	logic signed [34:0] num_s6;
	logic [15:0]        wr_s6;
	side_a_t            sa_s6;

	// s7: reach check
	logic               vld_s7;
	logic signed [29:0] num_s7;
	logic               reach_s7;
	logic [15:0]        wr_s7;
	side_a_t            sa_s7;
	logic signed [34:0] den_ext;

	// s8: numerator squared
	logic               vld_s8;
	logic signed [59:0] nsq_s8;
	side_b_t            sb_s8;

	// s9: sine squared scaled
	logic               vld_s9;
	logic [57:0]        diff_s9;
	side_b_t            sb_s9;

	logic               sin_vld;
	logic [28:0]        sin_r;
	side_b_t            sb_sin;

	// s10: forearm products
	logic               vld_s10;
	logic [42:0]        l3s_s10;
	logic signed [43:0] l3num_s10;
	logic [28:0]        s_s10;
	side_b_t            sb_s10;

	// s11: CORDIC operands
	logic               vld_s11;
	logic signed [AW-1:0] phi_y_s11, phi_x_s11, yaw_y_s11, yaw_x_s11;
	logic signed [AW-1:0] a1_y_s11, a1_x_s11, a2_y_s11, a2_x_s11;
	logic               reach_s11;

	logic               ang_vld;
	logic               ang_reach;
	logic signed [ZW-1:0] phi_ang, yaw_ang, a1_ang, a2_ang;

	logic signed [RW-1:0] yaw_w, sh_w, el_w, yaw_r, sh_r, el_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s1  <= point.valid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= rad_vld;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= sin_vld;
			vld_s11 <= vld_s10;
		end
	end

	assign wr_diff = $signed({1'b0, radial}) - $signed({3'b000, radial_offset_q});
	assign den_ext = $signed({6'd0, den_q});

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= point.target_x;
			y_s1 <= point.target_y;
			z_s1 <= point.target_z;

			xsq_s2 <= x_s1 * x_s1;
			ysq_s2 <= y_s1 * y_s1;
			x_s2   <= x_s1;
			y_s2   <= y_s1;
			wz_s2  <= {z_s1[15], z_s1} - {3'b000, base_height_q};

			rsq_s3   <= xsq_s2 + ysq_s2;
			sa_s3.x  <= x_s2;
			sa_s3.y  <= y_s2;
			sa_s3.wz <= wz_s2;

			wr_s4 <= (wr_diff < 17'sd16) ? 16'd16 : wr_diff[15:0];
			sa_s4 <= sa_rad;

			wrsq_s5 <= {16'd0, wr_s4} * {16'd0, wr_s4};
			wzsq_s5 <= sa_s4.wz * sa_s4.wz;
			wr_s5   <= wr_s4;
			sa_s5   <= sa_s4;

			num_s6 <= $signed({3'b000, wrsq_s5} + {3'b000, wzsq_s5[31:0]} - {6'd0, csum_q});
			wr_s6  <= wr_s5;
			sa_s6  <= sa_s5;

			reach_s7 <= !((num_s6 > den_ext) || (num_s6 < -den_ext));
			num_s7   <= num_s6[29:0];
			wr_s7    <= wr_s6;
			sa_s7    <= sa_s6;

			nsq_s8      <= num_s7 * num_s7;
			sb_s8.x     <= sa_s7.x;
			sb_s8.y     <= sa_s7.y;
			sb_s8.wz    <= sa_s7.wz;
			sb_s8.wr    <= wr_s7;
			sb_s8.num   <= num_s7;
			sb_s8.reach <= reach_s7;

			diff_s9 <= densq_q - nsq_s8[57:0];
			sb_s9   <= sb_s8;

			l3s_s10   <= {14'd0, sin_r} * {29'd0, forearm_length_q};
			l3num_s10 <= sb_sin.num * $signed({1'b0, forearm_length_q});
			s_s10     <= sin_r;
			sb_s10    <= sb_sin;

			phi_y_s11 <= $signed({19'd0, s_s10});
			phi_x_s11 <= AW'(sb_s10.num);
			yaw_y_s11 <= AW'(sb_s10.y);
			yaw_x_s11 <= AW'(sb_s10.x);
			a1_y_s11  <= AW'(sb_s10.wz);
			a1_x_s11  <= $signed({32'd0, sb_s10.wr});
			a2_y_s11  <= $signed({5'd0, l3s_s10});
			a2_x_s11  <= $signed({5'd0, l2den_q}) + AW'(l3num_s10);
			reach_s11 <= sb_s10.reach;
		end
	end

	ikp_isqrt #(
		.WIDTH  (32),
		.SIDE_W ($bits(side_a_t))
	) u_radius_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s3),
		.in_rad   (rsq_s3),
		.in_side  (sa_s3),
		.out_vld  (rad_vld),
		.out_root (radial),
		.out_side (sa_rad)
	);

	ikp_isqrt #(
		.WIDTH  (58),
		.SIDE_W ($bits(side_b_t))
	) u_sine_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s9),
		.in_rad   (diff_s9),
		.in_side  (sb_s9),
		.out_vld  (sin_vld),
		.out_root (sin_r),
		.out_side (sb_sin)
	);

	ikp_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_phi (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s11),
		.in_y     (phi_y_s11),
		.in_x     (phi_x_s11),
		.in_side  (reach_s11),
		.out_vld  (ang_vld),
		.out_ang  (phi_ang),
		.out_side (ang_reach)
	);

	ikp_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_yaw (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s11),
		.in_y     (yaw_y_s11),
		.in_x     (yaw_x_s11),
		.in_side  (1'b0),
		.out_vld  (),
		.out_ang  (yaw_ang),
		.out_side ()
	);

	ikp_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_wrist (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s11),
		.in_y     (a1_y_s11),
		.in_x     (a1_x_s11),
		.in_side  (1'b0),
		.out_vld  (),
		.out_ang  (a1_ang),
		.out_side ()
	);

	ikp_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(1)) u_offset (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (vld_s11),
		.in_y     (a2_y_s11),
		.in_x     (a2_x_s11),
		.in_side  (1'b0),
		.out_vld  (),
		.out_ang  (a2_ang),
		.out_side ()
	);

	// round 1/65536 degree to 1/256 degree, half up
	always_comb begin
		yaw_w = RW'(yaw_ang);
		sh_w  = RW'(a1_ang) - RW'(a2_ang);
		el_w  = RW'(phi_ang) - $signed({4'd0, forearm_angle_q, 8'd0});
		yaw_r = (yaw_w + RW'(128)) >>> 8;
		sh_r  = (sh_w + RW'(128)) >>> 8;
		el_r  = (el_w + RW'(128)) >>> 8;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joint.valid <= 1'b0;
		end else if (en) begin
			joint.valid <= ang_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			joint.reachable      <= ang_reach;
			joint.base_yaw       <= ang_reach ? yaw_r[16:0] : '0;
			joint.shoulder_angle <= ang_reach ? sh_r[17:0] : '0;
			joint.elbow_angle    <= ang_reach ? el_r[16:0] : '0;
		end
	end

`ifndef SYNTHESIS
	a_wrist_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |-> (wr_s4 >= 16'd16))
		else $error("wrist radius below clamp");

	a_unreach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(joint.valid && !joint.reachable) |->
		(joint.base_yaw == '0 && joint.shoulder_angle == '0 && joint.elbow_angle == '0))
		else $error("unreachable word carries nonzero angles");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	typedef struct packed {
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} point_t;

	typedef struct packed {
		logic signed [16:0] yaw;
		logic signed [17:0] shoulder;
		logic signed [16:0] elbow;
		logic               reach;
	} joint_t;

	localparam int LATENCY = 65 + ikp_pkg::CORDIC_STAGES_DEF;
	localparam int WATCHDOG_LIMIT = 4000;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [2:0] wr_index;
	logic [15:0] wr_data;

	ikp_point_if point_bus();
	ikp_joint_if joint_bus();

	arm_position_inverse_kinematics_unit dut (
		.clk(clk), .arst_n(arst_n), .point(point_bus.sink), .joint(joint_bus.source),
		.wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
	);

	// geometry copy
	longint g_radial, g_height, g_upper, g_fore, g_fangle;

	point_t pending_points[$];
	joint_t expected_joints[$];
	int errors = 0;
	int idle_cycles = 0;
	int send_wait = 0;
	int recv_wait = 0;

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic longint floor_shift(longint v, int k);
		return v >>> k;
	endfunction

	function automatic longint int_sqrt(longint n);
		longint r, b, m;
		r = 0;
		m = n;
		b = 64'sd1 <<< 62;
		while (b > m)
			b = b >>> 2;
		while (b != 0) begin
			if (m >= r + b) begin
				m = m - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic longint arc_tangent(longint yi, longint xi);
		longint atab [24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
			29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
		longint xa, ya, za, t, dx, dy, lim;
		xa = xi;
		ya = yi;
		za = 0;
		lim = 64'sd1 <<< 40;
		if (xa == 0 && ya == 0)
			return 0;
		while ((xa < 0 ? -xa : xa) < lim && (ya < 0 ? -ya : ya) < lim) begin
			xa = xa * 2;
			ya = ya * 2;
		end
		if (xa < 0) begin
			t = xa;
			if (ya >= 0) begin
				xa = ya;
				ya = -t;
				za = 90 * 65536;
			end else begin
				xa = -ya;
				ya = t;
				za = -90 * 65536;
			end
		end
		for (int i = 0; i < ikp_pkg::CORDIC_STAGES_DEF && i < 24; i++) begin
			dx = floor_shift(ya, i);
			dy = floor_shift(xa, i);
			if (ya > 0) begin
				xa = xa + dx;
				ya = ya - dy;
				za = za + atab[i];
			end else begin
				xa = xa - dx;
				ya = ya + dy;
				za = za - atab[i];
			end
		end
		return za;
	endfunction

	function automatic joint_t solve_joints(point_t p);
		longint x, y, z, wr, wz, num, den, s, phi, yaw, sh, el;
		joint_t r;
		x = p.x;
		y = p.y;
		z = p.z;
		wr = int_sqrt(x * x + y * y) - g_radial;
		if (wr < 16)
			wr = 16;
		wz = z - g_height;
		num = wr * wr + wz * wz - g_upper * g_upper - g_fore * g_fore;
		den = 2 * g_upper * g_fore;
		r = '0;
		if (num < -den || num > den)
			return r;
		s = int_sqrt(den * den - num * num);
		phi = arc_tangent(s, num);
		yaw = arc_tangent(y, x);
		sh = arc_tangent(wz, wr) - arc_tangent(g_fore * s, g_upper * den + g_fore * num);
		el = phi - g_fangle * 256;
		r.yaw = 17'(floor_shift(yaw + 128, 8));
		r.shoulder = 18'(floor_shift(sh + 128, 8));
		r.elbow = 17'(floor_shift(el + 128, 8));
		r.reach = 1'b1;
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_bus.valid <= 1'b0;
			point_bus.target_x <= '0;
			point_bus.target_y <= '0;
			point_bus.target_z <= '0;
			send_wait <= 0;
		end else begin
			if (point_bus.valid && point_bus.ready) begin
				expected_joints.push_back(solve_joints({point_bus.target_x,
					point_bus.target_y, point_bus.target_z}));
			end
			if (!point_bus.valid || point_bus.ready) begin
				if (send_wait > 0) begin
					point_bus.valid <= 1'b0;
					send_wait <= send_wait - 1;
				end else if (pending_points.size() > 0) begin
					point_t p;
					p = pending_points.pop_front();
					point_bus.valid <= 1'b1;
					point_bus.target_x <= p.x;
					point_bus.target_y <= p.y;
					point_bus.target_z <= p.z;
					send_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
				end else begin
					point_bus.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joint_bus.ready <= 1'b0;
			recv_wait <= 0;
		end else begin
			if (joint_bus.valid && joint_bus.ready) begin
				if (expected_joints.size() == 0) begin
					$error("unexpected joint word");
					errors++;
				end else begin
					joint_t e;
					e = expected_joints.pop_front();
					if (joint_bus.base_yaw !== e.yaw) begin
						$error("base_yaw exp %0d got %0d", e.yaw, joint_bus.base_yaw);
						errors++;
					end
					if (joint_bus.shoulder_angle !== e.shoulder) begin
						$error("shoulder_angle exp %0d got %0d", e.shoulder,
							joint_bus.shoulder_angle);
						errors++;
					end
					if (joint_bus.elbow_angle !== e.elbow) begin
						$error("elbow_angle exp %0d got %0d", e.elbow, joint_bus.elbow_angle);
						errors++;
					end
					if (joint_bus.reachable !== e.reach) begin
						$error("reachable exp %0b got %0b", e.reach, joint_bus.reachable);
						errors++;
					end
				end
			end
			if (recv_wait > 0) begin
				joint_bus.ready <= 1'b0;
				recv_wait <= recv_wait - 1;
			end else begin
				joint_bus.ready <= 1'b1;
				if (joint_bus.valid && joint_bus.ready)
					recv_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((point_bus.valid && point_bus.ready) || (joint_bus.valid && joint_bus.ready)
				|| !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic write_reg(ikp_pkg::reg_idx_t idx, logic [15:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			ikp_pkg::REG_RADIAL_OFFSET: g_radial = val[13:0];
			ikp_pkg::REG_BASE_HEIGHT: g_height = val[13:0];
			ikp_pkg::REG_UPPER_LINK: g_upper = val[13:0];
			ikp_pkg::REG_FOREARM_LENGTH: g_fore = val[13:0];
			default: g_fangle = val;
		endcase
		repeat (3) @(posedge clk);
	endtask

	task automatic drain_points();
		while (pending_points.size() > 0 || point_bus.valid || expected_joints.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	// points near the reachable shell of the current geometry
	function automatic point_t reachable_point();
		point_t p;
		longint r, h, ang;
		r = g_radial + $urandom_range(0, int'(g_upper + g_fore));
		h = g_height + longint'($urandom_range(0, int'(2 * (g_upper + g_fore))))
			- (g_upper + g_fore);
		ang = $urandom_range(0, 3);
		if (r > 32767)
			r = 32767;
		if (h > 32767)
			h = 32767;
		if (h < -32768)
			h = -32768;
		p.z = 16'(h);
		case (ang)
			0: begin p.x = 16'(r); p.y = 16'($urandom_range(0, 32767) % (r + 1)); end
			1: begin p.x = -16'(r / 2); p.y = 16'(r * 7 / 8); end
			2: begin p.x = -16'(r); p.y = -16'($urandom_range(0, int'(r)) / 3); end
			default: begin p.x = 16'(r * 5 / 8); p.y = -16'(r * 3 / 4); end
		endcase
		return p;
	endfunction

	task automatic random_phase(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 7)
				pending_points.push_back(reachable_point());
			else
				pending_points.push_back({16'($urandom), 16'($urandom), 16'($urandom)});
		end
		drain_points();
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = ikp_pkg::REG_RADIAL_OFFSET;
		wr_data = '0;
		g_radial = ikp_pkg::RADIAL_OFFSET_RST;
		g_height = ikp_pkg::BASE_HEIGHT_RST;
		g_upper = ikp_pkg::UPPER_LINK_RST;
		g_fore = ikp_pkg::FOREARM_LENGTH_RST;
		g_fangle = ikp_pkg::FOREARM_ANGLE_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		pending_points.push_back('{16'sd0, 16'sd0, 16'sd0});
		pending_points.push_back('{16'sd32767, 16'sd32767, 16'sd32767});
		pending_points.push_back('{-16'sd32768, -16'sd32768, -16'sd32768});
		pending_points.push_back('{16'sd5000, 16'sd0, 16'sd2656});
		pending_points.push_back('{-16'sd5000, 16'sd0, 16'sd2656});
		pending_points.push_back('{16'sd0, 16'sd5000, 16'sd4000});
		pending_points.push_back('{16'sd0, -16'sd5000, 16'sd1000});
		pending_points.push_back('{-16'sd3000, -16'sd3000, 16'sd2656});
		pending_points.push_back('{16'sd8160, 16'sd0, 16'sd2656});
		pending_points.push_back('{16'sd1760, 16'sd0, 16'sd2656});
		pending_points.push_back('{16'sd100, 16'sd100, 16'sd9000});
		pending_points.push_back('{-16'sd1, 16'sd0, -16'sd1});
		pending_points.push_back('{16'sd0, -16'sd1, 16'sd0});
		drain_points();
		random_phase(300);

		write_reg(ikp_pkg::REG_UPPER_LINK, 16'd0);
		write_reg(ikp_pkg::REG_FOREARM_LENGTH, 16'd0);
		pending_points.push_back('{16'sd1760, 16'sd0, 16'sd2656});
		pending_points.push_back('{16'sd1700, 16'sd0, 16'sd2656});
		pending_points.push_back('{16'sd1777, 16'sd0, 16'sd2656});
		drain_points();

		write_reg(ikp_pkg::REG_RADIAL_OFFSET, 16'd0);
		write_reg(ikp_pkg::REG_BASE_HEIGHT, 16'd0);
		write_reg(ikp_pkg::REG_UPPER_LINK, 16'd16);
		write_reg(ikp_pkg::REG_FOREARM_LENGTH, 16'd16);
		write_reg(ikp_pkg::REG_FOREARM_ANGLE, 16'd0);
		random_phase(250);

		write_reg(ikp_pkg::REG_RADIAL_OFFSET, 16'hFFFF);
		write_reg(ikp_pkg::REG_BASE_HEIGHT, 16'd16383);
		write_reg(ikp_pkg::REG_UPPER_LINK, 16'd16383);
		write_reg(ikp_pkg::REG_FOREARM_LENGTH, 16'd16383);
		write_reg(ikp_pkg::REG_FOREARM_ANGLE, 16'hFFFF);
		random_phase(250);

		write_reg(ikp_pkg::REG_RADIAL_OFFSET, 16'd500);
		write_reg(ikp_pkg::REG_BASE_HEIGHT, 16'd1000);
		write_reg(ikp_pkg::REG_UPPER_LINK, 16'd6000);
		write_reg(ikp_pkg::REG_FOREARM_LENGTH, 16'd2000);
		write_reg(ikp_pkg::REG_FOREARM_ANGLE, 16'd46080);
		random_phase(250);

		write_reg(ikp_pkg::REG_RADIAL_OFFSET, 16'($urandom_range(0, 16383)));
		write_reg(ikp_pkg::REG_BASE_HEIGHT, 16'($urandom_range(0, 16383)));
		write_reg(ikp_pkg::REG_UPPER_LINK, 16'($urandom_range(16, 8000)));
		write_reg(ikp_pkg::REG_FOREARM_LENGTH, 16'($urandom_range(16, 8000)));
		write_reg(ikp_pkg::REG_FOREARM_ANGLE, 16'($urandom_range(0, 46080)));
		random_phase(250);

		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/ikp_pkg.sv
sv/ikp_point_if.sv
sv/ikp_joint_if.sv
sv/ikp_isqrt.sv
sv/ikp_cordic.sv
sv/arm_position_inverse_kinematics_unit.sv
verif/testbench.sv
